// File: src/kxp_pkg.sv
// Shared types, constants and the mix function of the keyless XTEA permutation.
package kxp_pkg;

	localparam int          ROUND_COUNT_DEF = 32;
	localparam int          WORD_W          = 32;
	localparam logic [31:0] DELTA           = 32'h9E3779B9;

	localparam logic KIND_FORWARD = 1'b0;
	localparam logic KIND_INVERSE = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] second;
		logic [WORD_W-1:0] first;
	} item_t;

	function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

endpackage

// File: src/kxp_stage.sv
// One half-round of the permutation with its pipeline register.
module kxp_stage #(
	parameter int ROUND_COUNT = kxp_pkg::ROUND_COUNT_DEF,
	parameter int STAGE       = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  kxp_pkg::item_t  in_item,
	output logic            out_valid,
	output kxp_pkg::item_t  out_item
);

	// Running sum seen by this half-round, for either direction
	localparam int          SUM_IDX = (STAGE + 1) / 2;
	localparam logic        ODD     = (STAGE % 2) == 1;
	localparam logic [31:0] KEY_FWD = 32'(SUM_IDX) * kxp_pkg::DELTA;
	localparam logic [31:0] KEY_INV = 32'(ROUND_COUNT - SUM_IDX) * kxp_pkg::DELTA;

	logic                         valid_s1;
	kxp_pkg::item_t               item_s1;
	kxp_pkg::item_t               next_item;
	logic                         upd_first;
	logic [kxp_pkg::WORD_W-1:0]   src_word;
	logic [kxp_pkg::WORD_W-1:0]   dst_word;
	logic [kxp_pkg::WORD_W-1:0]   mix_val;
	logic [kxp_pkg::WORD_W-1:0]   new_word;

	always_comb begin
		upd_first = (ODD == in_item.kind);
		src_word  = upd_first ? in_item.second : in_item.first;
		dst_word  = upd_first ? in_item.first : in_item.second;
		mix_val   = kxp_pkg::mix_word(src_word)
			^ ((in_item.kind == kxp_pkg::KIND_INVERSE) ? KEY_INV : KEY_FWD);
		new_word  = (in_item.kind == kxp_pkg::KIND_INVERSE) ? (dst_word - mix_val)
			: (dst_word + mix_val);
		next_item = in_item;
		if (upd_first) begin
			next_item.first = new_word;
		end else begin
			next_item.second = new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			item_s1 <= next_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// File: src/kxp_out_buf.sv
// Output register with a skid entry; decouples the pipeline from the sink.
module kxp_out_buf (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  kxp_pkg::item_t               push_item,
	output logic                         space,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [2*kxp_pkg::WORD_W-1:0] m_tdata
);

	logic                         out_valid_q;
	logic [2*kxp_pkg::WORD_W-1:0] out_data_q;
	logic                         skid_valid_q;
	logic [2*kxp_pkg::WORD_W-1:0] skid_data_q;
	logic                         pop;
	logic [2*kxp_pkg::WORD_W-1:0] push_data;

	assign pop       = out_valid_q && m_tready;
	assign push_data = {push_item.second, push_item.first};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	// hold the pipeline while the skid entry is occupied
	assign space    = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: src/keyless_xtea_permutation.sv
// An input beat passes one register stage per half-round and then the output register.
// Throughput: one beat per cycle when not stalled; each half-round stage holds its own adders.
// A stalled output parks one beat in a skid entry and then holds the whole pipeline.
// Reset clears all valid bits asynchronously; data registers are not reset.
// Top level: pipeline of half-round stages feeding the output buffer.
module keyless_xtea_permutation #(
	parameter int ROUND_COUNT = kxp_pkg::ROUND_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [2*kxp_pkg::WORD_W-1:0] s_tdata,  // word_first, word_second
	input  logic                         s_tuser,  // kind
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [2*kxp_pkg::WORD_W-1:0] m_tdata   // out_first, out_second
);

	localparam int STAGES = 2 * ROUND_COUNT;

	logic           pipe_en;
	logic           stage_valid [0:STAGES];
	kxp_pkg::item_t stage_item  [0:STAGES];

	assign s_tready       = pipe_en;
	assign stage_valid[0] = s_tvalid;
	// kind above second above first
	assign stage_item[0]  = {s_tuser, s_tdata};

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		kxp_stage #(
			.ROUND_COUNT(ROUND_COUNT),
			.STAGE      (g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.in_valid (stage_valid[g]),
			.in_item  (stage_item[g]),
			.out_valid(stage_valid[g+1]),
			.out_item (stage_item[g+1])
		);
	end

	kxp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (pipe_en && stage_valid[STAGES]),
		.push_item(stage_item[STAGES]),
		.space    (pipe_en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> stage_valid[1])
		else $error("accepted beat did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> stage_valid[STAGES] == $past(stage_valid[STAGES]))
		else $error("pipeline moved while stalled");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |-> m_tvalid)
		else $error("skid entry full with empty output register");

	a_blocked_push_parks: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_en && stage_valid[STAGES] && m_tvalid && !m_tready |=> !pipe_en)
		else $error("blocked beat was not parked in the skid entry");
`endif

endmodule

// File: dv/keyless_xtea_permutation_tb.sv
// Self-checking testbench for the keyless XTEA permutation pipeline.
module keyless_xtea_permutation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W     = kxp_pkg::WORD_W;
	localparam int ROUNDS     = kxp_pkg::ROUND_COUNT_DEF;
	localparam int RAND_ITEMS = 600;
	localparam int HOLD_OFF   = 300;

	typedef struct {
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
	} block_t;

	class perm_tracker;
		block_t pending_blocks[$];
		int     mismatches;
		int     failures;

		function logic [WORD_W-1:0] churn(logic [WORD_W-1:0] x);
			return ((x << 4) ^ (x >> 5)) + x;
		endfunction

		function block_t permute(logic inverse, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			logic [WORD_W-1:0] sum;
			block_t            res;
			if (inverse == kxp_pkg::KIND_FORWARD) begin
				sum = '0;
				for (int r = 0; r < ROUNDS; r++) begin
					a   = a + (churn(b) ^ sum);
					sum = sum + kxp_pkg::DELTA;
					b   = b + (churn(a) ^ sum);
				end
			end else begin
				sum = WORD_W'(ROUNDS) * kxp_pkg::DELTA;
				for (int r = 0; r < ROUNDS; r++) begin
					b   = b - (churn(a) ^ sum);
					sum = sum - kxp_pkg::DELTA;
					a   = a - (churn(b) ^ sum);
				end
			end
			res.first  = a;
			res.second = b;
			return res;
		endfunction

		function void note_block(logic inverse, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			pending_blocks.push_back(permute(inverse, a, b));
		endfunction

		function void check_block(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			block_t want;
			if (pending_blocks.size() == 0) begin
				failures++;
				if (mismatches < 10)
					$display("%0t: unexpected beat first=%h second=%h", $realtime, a, b);
				mismatches++;
				return;
			end
			want = pending_blocks.pop_front();
			if (a !== want.first || b !== want.second) begin
				failures++;
				if (mismatches < 10)
					$display("%0t: mismatch first exp %h got %h, second exp %h got %h",
						$realtime, want.first, a, want.second, b);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_blocks.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [2*WORD_W-1:0] s_tdata;  // word_first, word_second
	logic                s_tuser;  // kind
	logic                m_tvalid;
	logic                m_tready;
	logic [2*WORD_W-1:0] m_tdata;  // out_first, out_second

	perm_tracker tracker = new();
	bit          steady;
	bit          hold_request;

	keyless_xtea_permutation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	initial begin
		#200000;
		$display("FAIL keyless_xtea_permutation");
		$finish;
	end

	// note accepted beats on both sides before the block updates
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tracker.note_block(s_tuser, s_tdata[WORD_W-1:0], s_tdata[2*WORD_W-1:WORD_W]);
		if (arst_n && m_tvalid && m_tready)
			tracker.check_block(m_tdata[WORD_W-1:0], m_tdata[2*WORD_W-1:WORD_W]);
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_OFF;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = steady || ($urandom_range(99) >= 10);
			end
		end
	end

	task automatic send_block(logic inverse, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 10) begin
			s_tvalid = 1'b0;
			s_tdata  = {$urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = inverse;
		s_tdata  = {b, a};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(WORD_W-1);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [WORD_W-1:0] edge_words[5];
		block_t            trip;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = kxp_pkg::KIND_FORWARD;
		s_tdata  = '0;
		edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h8000_0000,
			32'h0000_0001};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: word extremes and patterns through both directions
		for (int i = 0; i < 5; i++) begin
			send_block(kxp_pkg::KIND_FORWARD, edge_words[i], edge_words[4-i]);
			send_block(kxp_pkg::KIND_INVERSE, edge_words[i], edge_words[4-i]);
		end
		send_block(kxp_pkg::KIND_FORWARD, 32'hFFFF_FFFF, 32'h0000_0000);
		send_block(kxp_pkg::KIND_INVERSE, 32'h0000_0000, 32'hFFFF_FFFF);
		send_block(kxp_pkg::KIND_FORWARD, 32'h5555_5555, 32'hAAAA_AAAA);
		send_block(kxp_pkg::KIND_INVERSE, 32'h5555_5555, 32'hAAAA_AAAA);
		// round trip: inverse of a forward result must give the plain block back
		trip = tracker.permute(kxp_pkg::KIND_FORWARD, 32'h0123_4567, 32'h89AB_CDEF);
		send_block(kxp_pkg::KIND_FORWARD, 32'h0123_4567, 32'h89AB_CDEF);
		send_block(kxp_pkg::KIND_INVERSE, trip.first, trip.second);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 100)
				hold_request = 1'b1;
			steady = (n >= 300 && n < 420);
			send_block(1'($urandom_range(1)), pick_word(), pick_word());
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		steady   = 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		// drain: allow any stray beat to surface
		repeat (2*ROUNDS + 16) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("PASS keyless_xtea_permutation");
		else
			$display("FAIL keyless_xtea_permutation");
		$finish;
	end

endmodule
